// ===== hw/rtl/affine_volume_resampler_top_assert.svh =====
// assertion macros for the resampler top level
`ifndef AFFINE_VOLUME_RESAMPLER_TOP_ASSERT_SVH
`define AFFINE_VOLUME_RESAMPLER_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define AVR_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define AVR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/avr_pkg.sv =====
// ----------------------------------------------------------------------------
// avr_pkg
// types, constants and codes shared by the affine volume resampler
// ----------------------------------------------------------------------------
`default_nettype none

package avr_pkg;

  localparam int VOLUME_WORDS   = 65536;
  localparam int VOXEL_BITS     = 8;
  localparam int COORD_BITS     = 12;
  localparam int LOAD_ADDR_BITS = 16;
  localparam int ADDR_BITS      = $clog2(VOLUME_WORDS);
  localparam int DIM_BITS       = 10;
  localparam int Q_FRAC         = 16;
  localparam int COEF_BITS      = 32;
  localparam int MAP_BITS       = 64;
  localparam int DIMS_BITS      = 3 * DIM_BITS;
  localparam int MUL_BITS       = COEF_BITS + COORD_BITS + 1;
  localparam int P_BITS         = MUL_BITS + 2;
  localparam int W_BITS         = Q_FRAC + 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CFG_MAP_X_FIRST  = 3'd0,
    CFG_MAP_X_SECOND = 3'd1,
    CFG_MAP_Y_FIRST  = 3'd2,
    CFG_MAP_Y_SECOND = 3'd3,
    CFG_MAP_Z_FIRST  = 3'd4,
    CFG_MAP_Z_SECOND = 3'd5,
    CFG_SOURCE_DIMS  = 3'd6,
    CFG_INTERP_MODE  = 3'd7
  } cfg_index_t;

  localparam logic MODE_TRILINEAR = 1'b0;
  localparam logic MODE_NEAREST   = 1'b1;
  localparam logic ACT_LOAD       = 1'b0;
  localparam logic ACT_SAMPLE     = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [LOAD_ADDR_BITS-1:0] load_address;
    logic [VOXEL_BITS-1:0]     voxel_in;
    logic [COORD_BITS-1:0]     out_x;
    logic [COORD_BITS-1:0]     out_y;
    logic [COORD_BITS-1:0]     out_z;
  } item_t;

  typedef struct packed {
    logic [VOXEL_BITS-1:0] sample_value;
    logic                  in_bounds;
  } result_t;

  typedef struct packed {
    logic                  is_sample;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VOXEL_BITS-1:0] voxel;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COORD_BITS-1:0] oz;
  } job_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic [5:0][MAP_BITS-1:0] map;
    logic [DIMS_BITS-1:0]     dims;
    logic                     mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/avr_item_if.sv =====
// ----------------------------------------------------------------------------
// avr_item_if
// input channel: valid/ready handshake carrying one item word
// ----------------------------------------------------------------------------
`default_nettype none

interface avr_item_if;
  logic           valid;
  logic           ready;
  avr_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avr_result_if.sv =====
// ----------------------------------------------------------------------------
// avr_result_if
// result channel: valid/ready handshake carrying one result word
// ----------------------------------------------------------------------------
`default_nettype none

interface avr_result_if;
  logic             valid;
  logic             ready;
  avr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avr_front.sv =====
// ----------------------------------------------------------------------------
// avr_front
// accepts input words, classifies load or sample, drops loads beyond the store
// ----------------------------------------------------------------------------
`default_nettype none

module avr_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  avr_item_if.sink       in_ch,
  input  wire logic      q_ready,
  output avr_pkg::job_t  job,
  output logic           job_valid
);

  logic          hold_v_r;
  avr_pkg::job_t job_r;
  logic          take;
  logic          keep;

  // accept while the holding stage is free or draining into the queue
  assign in_ch.ready = !hold_v_r || q_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign keep        = (in_ch.data.action == avr_pkg::ACT_SAMPLE) ||
                       (32'(in_ch.data.load_address) < 32'(avr_pkg::VOLUME_WORDS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (take) begin
      hold_v_r <= keep;
    end else if (q_ready) begin
      hold_v_r <= 1'b0;
    end
  end

  // classify the word into a queue entry
  always_ff @(posedge clk) begin
    if (take) begin
      job_r.is_sample <= (in_ch.data.action == avr_pkg::ACT_SAMPLE);
      job_r.waddr     <= avr_pkg::ADDR_BITS'(in_ch.data.load_address);
      job_r.voxel     <= in_ch.data.voxel_in;
      job_r.ox        <= in_ch.data.out_x;
      job_r.oy        <= in_ch.data.out_y;
      job_r.oz        <= in_ch.data.out_z;
    end
  end

  assign job       = job_r;
  assign job_valid = hold_v_r;

endmodule

`default_nettype wire

// ===== hw/rtl/avr_queue.sv =====
// ----------------------------------------------------------------------------
// avr_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module avr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  avr_pkg::job_t       push_data,
  input  wire logic           pop,
  output avr_pkg::job_t       head,
  output avr_pkg::qstat_t     stat
);

  avr_pkg::job_t                    mem_r [avr_pkg::QUEUE_DEPTH];
  logic [avr_pkg::QPTR_BITS-1:0]    wr_ptr_r;
  logic [avr_pkg::QPTR_BITS-1:0]    rd_ptr_r;
  logic [avr_pkg::QCNT_BITS-1:0]    count_r;
  logic                             do_push;
  logic                             do_pop;

  assign stat.full  = (count_r == avr_pkg::QCNT_BITS'(avr_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/avr_back.sv =====
// ----------------------------------------------------------------------------
// avr_back
// executes queued words: volume store writes and affine sampling
// ----------------------------------------------------------------------------
`default_nettype none

module avr_back (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  avr_pkg::cfg_t  cfg,
  input  avr_pkg::job_t  job,
  input  wire logic      job_valid,
  output logic           job_pop,
  avr_result_if.source   out_ch
);

  localparam int AB    = avr_pkg::ADDR_BITS;
  localparam int DB    = avr_pkg::DIM_BITS;
  localparam int QF    = avr_pkg::Q_FRAC;
  localparam int PB    = avr_pkg::P_BITS;
  localparam int WB    = avr_pkg::W_BITS;
  localparam int VB    = avr_pkg::VOXEL_BITS;
  localparam int PRE_B = AB + DB;
  localparam int W1    = 2 * WB;
  localparam int W2    = W1 + VB;
  localparam int W3    = W2 + WB;
  localparam int SUMB  = W3 + 1;
  localparam int PAD   = PB - DB - QF;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_BND, S_PRE, S_RD, S_DRAIN, S_FIN
  } state_t;

  state_t state_r;

  // volume store
  logic [VB-1:0] vol_mem [avr_pkg::VOLUME_WORDS];
  logic [VB-1:0] mem_rdata_r;
  logic          mem_we;
  logic [AB-1:0] mem_raddr;

  // affine accumulation
  logic [1:0]                           row_r;
  logic [1:0]                           term_r;
  logic signed [PB-1:0]                 acc_r;
  logic signed [PB-1:0]                 p_r [3];
  logic [avr_pkg::COORD_BITS-1:0]       ox_r, oy_r, oz_r;
  logic [avr_pkg::MAP_BITS-1:0]         map_a, map_b;
  logic [avr_pkg::COEF_BITS-1:0]        coef;
  logic [avr_pkg::COORD_BITS-1:0]       coord;
  logic signed [avr_pkg::MUL_BITS-1:0]  prod;
  logic signed [PB-1:0]                 trans;
  logic signed [PB-1:0]                 acc_sum;

  // per-axis bounds and neighbors
  logic [DB-1:0]        size [3];
  logic signed [PB-1:0] lim [3];
  logic [2:0]           outside;
  logic [DB:0]          rn [3];
  logic [DB-1:0]        near [3];
  logic [DB-1:0]        lo_r [3];
  logic [DB-1:0]        hi_r [3];
  logic [WB-1:0]        wlo_r [3];
  logic [WB-1:0]        whi_r [3];

  // address products
  logic [2:0]       pre_cnt_r;
  logic [DB-1:0]    mul_a;
  logic [AB-1:0]    mul_b;
  logic [PRE_B-1:0] pre_prod;
  logic [AB-1:0]    sxsy_r, ylo_r, yhi_r, zlo_r, zhi_r;

  // corner pipeline
  logic [3:0]      corner_r;
  logic [WB-1:0]   wx, wy, wz;
  logic [W1-1:0]   wxy;
  logic            s1_v_r, s2_v_r, s3_v_r;
  logic [W1-1:0]   s1_wxy_r;
  logic [WB-1:0]   s1_wz_r, s2_wz_r;
  logic [W2-1:0]   s2_m_r;
  logic [W3-1:0]   s3_m_r;
  logic [SUMB-1:0] sum_r;
  logic [SUMB-1:0] rnd;

  // pending and registered result
  logic              res_val_r;
  logic [VB-1:0]     res_value_r;
  logic              out_v_r;
  avr_pkg::result_t  out_d_r;
  logic              slot_free;

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign mem_we    = job_pop && !job.is_sample;
  assign slot_free = !out_v_r || out_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  assign size[0] = cfg.dims[DB-1:0];
  assign size[1] = cfg.dims[2*DB-1:DB];
  assign size[2] = cfg.dims[3*DB-1:2*DB];

  // shared multiply-accumulate operand select
  always_comb begin
    map_a = cfg.map[{row_r, 1'b0}];
    map_b = cfg.map[{row_r, 1'b1}];
    case (term_r)
      2'd0:    begin coef = map_a[31:0];  coord = ox_r; end
      2'd1:    begin coef = map_a[63:32]; coord = oy_r; end
      2'd2:    begin coef = map_b[31:0];  coord = oz_r; end
      default: begin coef = '0;           coord = '0;   end
    endcase
    prod    = $signed(coef) * $signed({1'b0, coord});
    trans   = PB'($signed(map_b[63:32]));
    acc_sum = acc_r + PB'(prod);
  end

  // bounds check and nearest index per axis
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lim[r]     = $signed({{PAD{1'b0}}, size[r], {QF{1'b0}}}) -
                   $signed(PB'(1) <<< QF);
      outside[r] = (p_r[r] < 0) || (p_r[r] > lim[r]);
      rn[r]      = p_r[r][DB+QF:QF] + (DB+1)'(p_r[r][QF-1]);
      near[r]    = (rn[r] > {1'b0, size[r] - 1'b1}) ? size[r] - 1'b1 : rn[r][DB-1:0];
    end
  end

  // shared address multiplier
  always_comb begin
    case (pre_cnt_r)
      3'd0:    begin mul_a = size[1]; mul_b = AB'(size[0]); end
      3'd1:    begin mul_a = lo_r[1]; mul_b = AB'(size[0]); end
      3'd2:    begin mul_a = hi_r[1]; mul_b = AB'(size[0]); end
      3'd3:    begin mul_a = lo_r[2]; mul_b = sxsy_r;       end
      3'd4:    begin mul_a = hi_r[2]; mul_b = sxsy_r;       end
      default: begin mul_a = '0;      mul_b = '0;           end
    endcase
    pre_prod = PRE_B'(mul_a) * PRE_B'(mul_b);
  end

  // corner address and weights
  always_comb begin
    mem_raddr = AB'(corner_r[0] ? hi_r[0] : lo_r[0]) +
                (corner_r[1] ? yhi_r : ylo_r) +
                (corner_r[2] ? zhi_r : zlo_r);
    wx  = corner_r[0] ? whi_r[0] : wlo_r[0];
    wy  = corner_r[1] ? whi_r[1] : wlo_r[1];
    wz  = corner_r[2] ? whi_r[2] : wlo_r[2];
    wxy = W1'(wx) * W1'(wy);
    rnd = sum_r + (SUMB'(1) << (3 * QF - 1));
  end

  // volume store port
  always_ff @(posedge clk) begin
    if (mem_we) vol_mem[job.waddr] <= job.voxel;
    mem_rdata_r <= vol_mem[mem_raddr];
  end

  // sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;

      // corner product pipeline
      s1_v_r   <= (state_r == S_RD);
      s1_wxy_r <= wxy;
      s1_wz_r  <= wz;
      s2_v_r   <= s1_v_r;
      s2_m_r   <= W2'(s1_wxy_r) * W2'(mem_rdata_r);
      s2_wz_r  <= s1_wz_r;
      s3_v_r   <= s2_v_r;
      s3_m_r   <= W3'(s2_m_r) * W3'(s2_wz_r);
      if (s3_v_r) sum_r <= sum_r + SUMB'(s3_m_r);

      unique case (state_r)
        S_IDLE: begin
          if (job_pop && job.is_sample) begin
            ox_r    <= job.ox;
            oy_r    <= job.oy;
            oz_r    <= job.oz;
            row_r   <= '0;
            term_r  <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (term_r == 2'd2) begin
            p_r[row_r] <= acc_sum + trans;
            acc_r      <= '0;
            term_r     <= '0;
            row_r      <= row_r + 1'b1;
            if (row_r == 2'd2) state_r <= S_BND;
          end else begin
            acc_r  <= acc_sum;
            term_r <= term_r + 1'b1;
          end
        end
        S_BND: begin
          for (int r = 0; r < 3; r++) begin
            if (cfg.mode == avr_pkg::MODE_NEAREST) begin
              lo_r[r]  <= near[r];
              hi_r[r]  <= near[r];
              wlo_r[r] <= WB'(1) << QF;
              whi_r[r] <= '0;
            end else begin
              lo_r[r]  <= p_r[r][DB+QF-1:QF];
              hi_r[r]  <= p_r[r][DB+QF-1:QF] + DB'(p_r[r][QF-1:0] != '0);
              wlo_r[r] <= (WB'(1) << QF) - WB'(p_r[r][QF-1:0]);
              whi_r[r] <= WB'(p_r[r][QF-1:0]);
            end
          end
          if (outside != 3'b000) begin
            res_val_r   <= 1'b0;
            res_value_r <= '0;
            state_r     <= S_FIN;
          end else begin
            pre_cnt_r <= '0;
            state_r   <= S_PRE;
          end
        end
        S_PRE: begin
          case (pre_cnt_r)
            3'd0:    sxsy_r <= AB'(pre_prod);
            3'd1:    ylo_r  <= AB'(pre_prod);
            3'd2:    yhi_r  <= AB'(pre_prod);
            3'd3:    zlo_r  <= AB'(pre_prod);
            default: zhi_r  <= AB'(pre_prod);
          endcase
          pre_cnt_r <= pre_cnt_r + 1'b1;
          if (pre_cnt_r == 3'd4) begin
            corner_r <= '0;
            sum_r    <= '0;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          corner_r <= corner_r + 1'b1;
          if (corner_r == 4'd7) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r) begin
            res_val_r   <= 1'b1;
            res_value_r <= rnd[3*QF+VB-1:3*QF];
            state_r     <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_v_r              <= 1'b1;
            out_d_r.sample_value <= res_value_r;
            out_d_r.in_bounds    <= res_val_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/affine_volume_resampler_top.sv =====
// ----------------------------------------------------------------------------
// affine_volume_resampler_top
// inverse affine 3-d resampler over a loaded source volume, one channel
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries words: a load writes voxel_in at load_address into the
//   volume store and gives no result; a sample maps (out_x, out_y, out_z)
//   through the inverse affine rows and gives one result word on out_ch.
//   cfg_we/cfg_index/cfg_wdata write the map rows, source_dims and
//   interp_mode; write them only while the block is idle.
// sequence:
//   a load is a store write in the back end. a sample is popped, runs
//   the three rows on the shared multiply-accumulate, passes the bounds check,
//   forms the address products on the shared address multiplier, reads the
//   corners from the single store port, drains the corner pipeline and moves
//   into the output register; an out-of-bounds sample skips to that register.
//   nearest mode runs the same corner sequence with one unit weight, rest zero.
// reset and stall:
//   rst_n (synchronous) clears the handshake state and the configuration
//   registers to 0; the volume store is not cleared. a stalled receiver holds
//   the result in the output register while the front and the 4-word queue
//   keep taking words until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_volume_resampler_top_assert.svh"

module affine_volume_resampler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  avr_item_if.sink         in_ch,
  avr_result_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  avr_pkg::cfg_t   cfg_r;
  avr_pkg::job_t   front_job;
  logic            front_valid;
  avr_pkg::job_t   q_head;
  avr_pkg::qstat_t qstat;
  logic            q_push;
  logic            q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (avr_pkg::cfg_index_t'(cfg_index))
        avr_pkg::CFG_MAP_X_FIRST:  cfg_r.map[0] <= cfg_wdata;
        avr_pkg::CFG_MAP_X_SECOND: cfg_r.map[1] <= cfg_wdata;
        avr_pkg::CFG_MAP_Y_FIRST:  cfg_r.map[2] <= cfg_wdata;
        avr_pkg::CFG_MAP_Y_SECOND: cfg_r.map[3] <= cfg_wdata;
        avr_pkg::CFG_MAP_Z_FIRST:  cfg_r.map[4] <= cfg_wdata;
        avr_pkg::CFG_MAP_Z_SECOND: cfg_r.map[5] <= cfg_wdata;
        avr_pkg::CFG_SOURCE_DIMS:  cfg_r.dims   <= cfg_wdata[avr_pkg::DIMS_BITS-1:0];
        avr_pkg::CFG_INTERP_MODE:  cfg_r.mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign q_push = front_valid && !qstat.full;

  avr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_ready   (!qstat.full),
    .job       (front_job),
    .job_valid (front_valid)
  );

  avr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_job),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (qstat)
  );

  avr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (q_head),
    .job_valid (!qstat.empty),
    .job_pop   (q_pop),
    .out_ch    (out_ch)
  );

  // queue sanity
  `AVR_ASSERT_NOW(a_q_no_overflow, clk, rst_n, q_push, !qstat.full, "queue push while full")
  `AVR_ASSERT_NOW(a_q_count_max, clk, rst_n, 1'b1, qstat.count <= avr_pkg::QCNT_BITS'(avr_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `AVR_ASSERT_NEXT(a_q_stays_empty, clk, rst_n, qstat.empty && !q_push, qstat.empty, "queue filled without a push")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the affine volume resampler: loads source boxes,
// samples them under several map/dims/mode settings and checks every result
// word against a directed expectation or an in-bench resampling predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import avr_pkg::*;

  localparam int WATCH_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 40;
  localparam int NUM_PHASES  = 9;
  localparam int RAND_ITEMS  = 90;

  typedef struct {
    item_t   it;
    bit      known;
    result_t res;
  } dir_row_t;

  typedef struct {
    bit      known;
    result_t res;
  } hint_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  avr_item_if   in_if ();
  avr_result_if out_if ();

  affine_volume_resampler_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: register copy, voxel store and which entries the stream writes
  logic [MAP_BITS-1:0]  map_q [6];
  logic [DIMS_BITS-1:0] dims_q;
  logic                 mode_q;
  logic [VOXEL_BITS-1:0] voxel_mem [VOLUME_WORDS];
  bit                    planned [VOLUME_WORDS];

  result_t pending_results [$];
  hint_t   typed_hints [$];
  dir_row_t dir_rows [$];

  int  mismatches;
  int  samples_sent;
  int  idle_cycles;
  bit  long_hold_done;
  int  stall_pct;
  int  stall_left;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [VOXEL_BITS-1:0] fetch_voxel(
      input longint unsigned x, input longint unsigned y, input longint unsigned z,
      input longint unsigned sx, input longint unsigned sy, inout bit reads_ok);
    longint unsigned a;
    a = (x + y * sx + z * sx * sy) % VOLUME_WORDS;
    if (!planned[a]) reads_ok = 0;
    return voxel_mem[a];
  endfunction

  function automatic void resample(input item_t it, output result_t r, output bit reads_ok);
    longint          pos [3];
    longint unsigned coord [3], sz [3], lo [3], hi [3], fr [3], nn [3];
    longint unsigned wl, wr, wt, wb, wu, wd, top, bot, total;
    longint unsigned slab [2];
    longint unsigned zz;
    bit in_vol;
    coord[0] = it.out_x;
    coord[1] = it.out_y;
    coord[2] = it.out_z;
    sz[0] = dims_q[9:0];
    sz[1] = dims_q[19:10];
    sz[2] = dims_q[29:20];
    reads_ok = 1;
    in_vol = 1;
    // map through the inverse rows, exact q16.16
    for (int k = 0; k < 3; k++) begin
      pos[k] = longint'($signed(map_q[2*k][31:0])) * longint'(coord[0])
             + longint'($signed(map_q[2*k][63:32])) * longint'(coord[1])
             + longint'($signed(map_q[2*k+1][31:0])) * longint'(coord[2])
             + longint'($signed(map_q[2*k+1][63:32]));
      if (pos[k] < 0 || pos[k] > (longint'(sz[k]) - 1) * 65536) in_vol = 0;
    end
    r = '0;
    if (!in_vol) return;
    for (int k = 0; k < 3; k++) begin
      lo[k] = longint'(pos[k]) >> 16;
      fr[k] = pos[k] & 64'hFFFF;
      hi[k] = lo[k] + (fr[k] != 0);
    end
    r.in_bounds = 1'b1;
    if (mode_q == MODE_NEAREST) begin
      // round half up, then clamp
      for (int k = 0; k < 3; k++) begin
        nn[k] = (longint'(pos[k]) + 64'h8000) >> 16;
        if (nn[k] > sz[k] - 1) nn[k] = sz[k] - 1;
      end
      r.sample_value = fetch_voxel(nn[0], nn[1], nn[2], sz[0], sz[1], reads_ok);
    end else begin
      // eight-corner blend, q8.48 sum rounded half up
      wl = 65536 - fr[0]; wr = fr[0];
      wt = 65536 - fr[1]; wb = fr[1];
      wu = 65536 - fr[2]; wd = fr[2];
      for (int k = 0; k < 2; k++) begin
        zz = k ? hi[2] : lo[2];
        top = wl * fetch_voxel(lo[0], lo[1], zz, sz[0], sz[1], reads_ok)
            + wr * fetch_voxel(hi[0], lo[1], zz, sz[0], sz[1], reads_ok);
        bot = wl * fetch_voxel(lo[0], hi[1], zz, sz[0], sz[1], reads_ok)
            + wr * fetch_voxel(hi[0], hi[1], zz, sz[0], sz[1], reads_ok);
        slab[k] = wt * top + wb * bot;
      end
      total = wu * slab[0] + wd * slab[1];
      r.sample_value = (total + (64'd1 << 47)) >> 48;
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  result_t prediction;
  bit      pred_ok;
  hint_t   hint;
  result_t want;

  // input acceptance: update store or queue the expected word
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      if (in_if.data.action == ACT_LOAD) begin
        voxel_mem[in_if.data.load_address] = in_if.data.voxel_in;
      end else begin
        resample(in_if.data, prediction, pred_ok);
        hint = typed_hints.pop_front();
        pending_results.push_back(hint.known ? hint.res : prediction);
      end
    end
  end

  // result acceptance: compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, value", out_if.data.sample_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.sample_value !== want.sample_value)
          report_mismatch("sample_value", out_if.data.sample_value, want.sample_value);
        if (out_if.data.in_bounds !== want.in_bounds)
          report_mismatch("in_bounds", out_if.data.in_bounds, want.in_bounds);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls in changing stretches, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!long_hold_done && samples_sent > 300) begin
      long_hold_done <= 1'b1;
      stall_left <= 400;
      out_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 2) * 30;
      if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(8, 40);
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_word(input item_t it, input bit known, input result_t res);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap  = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (it.action == ACT_SAMPLE) begin
      typed_hints.push_back('{known, res});
      samples_sent++;
    end else begin
      planned[it.load_address] = 1;
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SOURCE_DIMS: dims_q = val[DIMS_BITS-1:0];
      CFG_INTERP_MODE: mode_q = val[0];
      default:         map_q[idx] = val;
    endcase
    @(posedge clk);
  endtask

  // wait until every sample has answered and the back end has drained
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic item_t rand_word(input logic act);
    item_t it;
    it = $bits(item_t)'({$urandom, $urandom});
    it.action = act;
    return it;
  endfunction

  function automatic logic [63:0] q_pair(input int first, input int second);
    return {32'(second), 32'(first)};
  endfunction

  // set the registers of one phase
  task automatic set_phase(input int ph);
    int sx, sy, sz;
    case (ph)
      0, 1: begin
        sx = 4; sy = 4; sz = 4;
        write_reg(CFG_MAP_X_FIRST,  q_pair(32'h10000, 0));
        write_reg(CFG_MAP_X_SECOND, q_pair(0, ph ? 32'h8000 : 0));
        write_reg(CFG_MAP_Y_FIRST,  q_pair(0, 32'h10000));
        write_reg(CFG_MAP_Y_SECOND, q_pair(0, ph ? 32'h8000 : 0));
        write_reg(CFG_MAP_Z_FIRST,  q_pair(0, 0));
        write_reg(CFG_MAP_Z_SECOND, q_pair(32'h10000, ph ? 32'h8000 : 0));
        write_reg(CFG_INTERP_MODE,  ph ? MODE_NEAREST : MODE_TRILINEAR);
      end
      4, 5, 7: begin
        if (ph == 4) begin sx = 1023; sy = 1023; sz = 1023; end
        else if (ph == 5) begin sx = 5; sy = 0; sz = 5; end
        else begin
          sx = $urandom_range(2, 6); sy = $urandom_range(2, 6); sz = $urandom_range(2, 4);
        end
        // mirror x in phase 7, plain identity otherwise
        write_reg(CFG_MAP_X_FIRST,  q_pair(ph == 7 ? 32'hFFFF0000 : 32'h10000, 0));
        write_reg(CFG_MAP_X_SECOND, q_pair(0, ph == 7 ? (sx - 1) << 16 : 0));
        write_reg(CFG_MAP_Y_FIRST,  q_pair(0, 32'h10000));
        write_reg(CFG_MAP_Y_SECOND, q_pair(0, 0));
        write_reg(CFG_MAP_Z_FIRST,  q_pair(0, 0));
        write_reg(CFG_MAP_Z_SECOND, q_pair(32'h10000, 0));
        write_reg(CFG_INTERP_MODE,  MODE_TRILINEAR);
      end
      6: begin
        // unconstrained words: extreme coefficients, mostly out of bounds
        for (int k = 0; k < 6; k++) write_reg(cfg_index_t'(k), {$urandom, $urandom});
        write_reg(CFG_MAP_X_FIRST, {32'h80000000, 32'h7FFFFFFF});
        write_reg(CFG_INTERP_MODE, $urandom_range(0, 1));
        sx = $urandom_range(0, 1023); sy = $urandom_range(0, 1023); sz = $urandom_range(0, 1023);
      end
      default: begin
        // fractional scaling with small cross terms
        if (ph == 8) begin sx = 1; sy = 1; sz = 1; end
        else begin
          sx = $urandom_range(2, 6); sy = $urandom_range(2, 6); sz = $urandom_range(2, 4);
        end
        for (int k = 0; k < 3; k++) begin
          write_reg(cfg_index_t'(2*k), q_pair(
            k == 0 ? $urandom_range(32'h4000, 32'h18000) : $urandom_range(0, 32'h3000),
            k == 1 ? $urandom_range(32'h4000, 32'h18000) : $urandom_range(0, 32'h3000)));
          write_reg(cfg_index_t'(2*k+1), q_pair(
            k == 2 ? $urandom_range(32'h4000, 32'h18000) : $urandom_range(0, 32'h3000),
            $urandom_range(0, 32'h18000)));
        end
        write_reg(CFG_INTERP_MODE, ph == 3 ? MODE_NEAREST : $urandom_range(0, 1));
      end
    endcase
    write_reg(CFG_SOURCE_DIMS, {10'(sz), 10'(sy), 10'(sx)});
    cfg_we <= 1'b0;
  endtask

  // load every voxel of a small box at the low corner of the volume
  task automatic load_box();
    item_t it;
    int bx, by, bz;
    bx = dims_q[9:0]   < 5 ? dims_q[9:0]   : 5;
    by = dims_q[19:10] < 5 ? dims_q[19:10] : 5;
    bz = dims_q[29:20] < 3 ? dims_q[29:20] : 3;
    for (int z = 0; z < bz; z++)
      for (int y = 0; y < by; y++)
        for (int x = 0; x < bx; x++) begin
          it = rand_word(ACT_LOAD);
          it.load_address = 16'(x + y * dims_q[9:0] + z * dims_q[9:0] * dims_q[19:10]);
          send_word(it, 1'b0, '0);
        end
  endtask

  // random sample whose corner reads all hit written entries
  task automatic send_random_sample();
    item_t   it;
    result_t r;
    bit      ok;
    ok = 0;
    for (int t = 0; t < 20 && !ok; t++) begin
      it = rand_word(ACT_SAMPLE);
      if ($urandom_range(0, 9) < 7) begin
        it.out_x = $urandom_range(0, 6);
        it.out_y = $urandom_range(0, 6);
        it.out_z = $urandom_range(0, 4);
      end
      resample(it, r, ok);
    end
    if (ok) send_word(it, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    item_t it;
    clk = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAP_X_FIRST;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    mismatches = 0;
    samples_sent = 0;
    idle_cycles = 0;
    long_hold_done = 0;
    stall_pct = 0;
    stall_left = 0;
    for (int k = 0; k < 6; k++) map_q[k] = '0;
    dims_q = '0;
    mode_q = MODE_TRILINEAR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity over a 4x4x4 source, corners, edges and outside points
    set_phase(0);
    load_box();
    it = '0; it.action = ACT_SAMPLE;
    dir_rows.push_back('{it, 1'b0, '0});
    it.out_x = 3; it.out_y = 3; it.out_z = 2;
    dir_rows.push_back('{it, 1'b0, '0});
    it.out_x = 4; it.out_y = 0; it.out_z = 0;
    dir_rows.push_back('{it, 1'b1, '0});
    it.out_x = 0; it.out_y = 4;
    dir_rows.push_back('{it, 1'b1, '0});
    it.out_y = 0; it.out_z = 4;
    dir_rows.push_back('{it, 1'b1, '0});
    it.out_x = 12'hFFF; it.out_y = 12'hFFF; it.out_z = 12'hFFF;
    dir_rows.push_back('{it, 1'b1, '0});
    it = '0; it.load_address = 16'hFFFF; it.voxel_in = 8'hFF;
    dir_rows.push_back('{it, 1'b0, '0});
    it = '0; it.voxel_in = 8'hFF;
    dir_rows.push_back('{it, 1'b0, '0});
    it = '0; it.action = ACT_SAMPLE;
    dir_rows.push_back('{it, 1'b0, '0});
    it.out_x = 1; it.out_y = 2; it.out_z = 2;
    dir_rows.push_back('{it, 1'b0, '0});
    it = '0; it.load_address = 16'd21; it.voxel_in = 8'h00;
    dir_rows.push_back('{it, 1'b0, '0});
    it = '0; it.action = ACT_SAMPLE; it.out_x = 1; it.out_y = 1; it.out_z = 1;
    dir_rows.push_back('{it, 1'b0, '0});
    foreach (dir_rows[i]) send_word(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);
    drain_block();

    // random phases over several register settings
    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      set_phase(ph);
      load_box();
      for (int n = 0; n < RAND_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise load anywhere in the store
            send_word(rand_word(ACT_LOAD), 1'b0, '0);
          end
          1: begin
            // refresh a voxel at one of the low store addresses where the box starts
            it = rand_word(ACT_LOAD);
            it.load_address = $urandom_range(0, 24);
            send_word(it, 1'b0, '0);
          end
          default: send_random_sample();
        endcase
      end
      drain_block();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
